// ----- rtl/sliding_window_median_top_assert.svh -----
// Assertion macros used by the sliding window median datapath.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Concurrent check on the rising clock edge, ignored while reset is high.
`define SWM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Condition that must never be true outside reset.
`define SWM_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SWM_ASSERT(label, prop, msg)
`define SWM_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- rtl/swm_pkg.sv -----
// Types and constants shared by the sliding window median modules.
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 7;

   localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } ctrl_state_type;

   typedef struct packed {
      logic load_sample;
      logic do_update;
      logic cfg_write;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_full;
   } status_type;

endpackage

// ----- rtl/swm_if.sv -----
// Valid/ready channel interfaces for samples, medians and the window size register.
interface swm_req_if import swm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

interface swm_csr_if import swm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

// ----- rtl/sliding_window_median_top.sv -----
// Sliding window median filter: each accepted sample goes through capture, then update.
// A median is written to the result register by the update that follows its sample's
// capture; an update that produces a result waits while the earlier one is untransferred.
// A new sample is taken only once the last one is updated, as the oldest sample is first
// read from the arrival RAM into a register and then one parallel compare-and-shift step runs.
// Reset clears the fill count, the oldest pointer and any pending result and sets the
// window size to 3; the arrival RAM and the sorted row are not cleared.
module sliding_window_median_top import swm_pkg::*; #(
   parameter int WINDOW_MAX = 64
) (
   input logic       clock,
   input logic       reset,
   swm_req_if.sink   req_chan,
   swm_rsp_if.source rsp_chan,
   swm_csr_if.sink   csr_chan
);

   // The controller and the datapath meet only through these two structs.
   cmd_type    cmd;
   status_type status;

   // The controller takes a sample transfer in its idle state and then runs the update.
   // That update is held off only when it would overwrite a result that has not yet been
   // transferred, and while it is held off the next sample transfer is refused.
   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the samples twice: in arrival order in a RAM and in ascending
   // order in a row of registers. A window size write restarts the stream, so the
   // window has to fill again before the next median is produced.
   swm_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_chan.sample),
      .csr_data   (csr_chan.window_size),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_median (rsp_chan.median)
   );

endmodule

// ----- rtl/swm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swm_ctrl.sv -----
// Controller state machine: sequences sample capture and the sorted-row update.
module swm_ctrl import swm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       rsp_ready,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           stall;

   // An update that produces a result waits while the previous one is still unclaimed.
   assign stall = status.emit && status.out_full && !rsp_ready;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.load_sample = 1'b0;
      cmd.do_update   = 1'b0;
      cmd.cfg_write   = csr_valid;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!stall) begin
               cmd.do_update = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/swm_datapath.sv -----
// Datapath: arrival RAM, sorted register row, window counters and result register.
module swm_datapath import swm_pkg::*; #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [CFG_W-1:0]    csr_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_median
);

`include "sliding_window_median_top_assert.svh"

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [CFG_W-1:0]    window_size_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [IDX_W-1:0]    ptr_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] median_ff;
   logic [SAMPLE_W-1:0] sorted_ff [WINDOW_MAX];
   logic [SAMPLE_W-1:0] sorted_in [WINDOW_MAX];

   logic [31:0]         n_wide;
   logic [CNT_W-1:0]    n_eff;
   logic [CNT_W-1:0]    live_len;
   logic [CNT_W-1:0]    fill_inc;
   logic [CNT_W-1:0]    ptr_inc;
   logic [CNT_W-1:0]    med_full;
   logic [IDX_W-1:0]    med_idx;
   logic [IDX_W-1:0]    wr_addr;
   logic [SAMPLE_W-1:0] old_val;
   logic                full;
   logic                emit;

   logic                self_le [WINDOW_MAX];
   logic                keep    [WINDOW_MAX];
   logic                rem_le  [WINDOW_MAX];
   logic [SAMPLE_W-1:0] rem_val [WINDOW_MAX];

   // Effective window length: zero acts as one, large values saturate.
   always_comb begin
      if (window_size_ff == '0) begin
         n_wide = 32'd1;
      end else if (32'(window_size_ff) > WINDOW_MAX) begin
         n_wide = 32'(WINDOW_MAX);
      end else begin
         n_wide = 32'(window_size_ff);
      end
   end

   assign n_eff    = n_wide[CNT_W-1:0];
   assign full     = (fill_ff == n_eff);
   assign fill_inc = fill_ff + CNT_W'(1);
   assign ptr_inc  = CNT_W'(ptr_ff) + CNT_W'(1);
   assign emit     = full || (fill_inc == n_eff);
   assign live_len = full ? (n_eff - CNT_W'(1)) : fill_ff;
   assign med_full = (n_eff - CNT_W'(1)) >> 1;
   assign med_idx  = med_full[IDX_W-1:0];
   assign wr_addr  = full ? ptr_ff : fill_ff[IDX_W-1:0];

   swm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.do_update),
      .wr_addr (wr_addr),
      .wr_data (sample_ff),
      .rd_en   (cmd.load_sample),
      .rd_addr (ptr_ff),
      .rd_data (old_val)
   );

   // Each cell works out its next value from itself and its neighbors: once the window is full,
   // the oldest value is first deleted (cells at or above it take the upper neighbor), then the
   // new sample lands after every remaining entry that is not greater than it.
   for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
      logic [SAMPLE_W-1:0] upper;
      logic                upper_le;

      if (g + 1 < WINDOW_MAX) begin : g_mid
         assign upper    = sorted_ff[g+1];
         assign upper_le = self_le[g+1];
      end else begin : g_last
         assign upper    = sorted_ff[g];
         assign upper_le = self_le[g];
      end

      assign self_le[g] = ($signed(sorted_ff[g]) <= $signed(sample_ff));
      assign keep[g]    = !full ||
                          ((CNT_W'(g) < n_eff) && ($signed(sorted_ff[g]) < $signed(old_val)));
      assign rem_val[g] = keep[g] ? sorted_ff[g] : upper;
      assign rem_le[g]  = (CNT_W'(g) < live_len) && (keep[g] ? self_le[g] : upper_le);

      if (g == 0) begin : g_first
         assign sorted_in[g] = rem_le[g] ? rem_val[g] : sample_ff;
      end else begin : g_rest
         assign sorted_in[g] = rem_le[g] ? rem_val[g] :
                               (rem_le[g-1] ? sample_ff : rem_val[g-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
         fill_ff        <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.cfg_write) begin
            window_size_ff <= csr_data;
            fill_ff        <= '0;
            ptr_ff         <= '0;
         end else if (cmd.do_update) begin
            if (!full) begin
               fill_ff <= fill_inc;
               ptr_ff  <= '0;
            end else if (ptr_inc == n_eff) begin
               ptr_ff <= '0;
            end else begin
               ptr_ff <= ptr_inc[IDX_W-1:0];
            end
         end
         if (cmd.do_update && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.do_update) begin
         sorted_ff <= sorted_in;
      end
      if (cmd.do_update && emit) begin
         median_ff <= sorted_in[med_idx];
      end
   end

   assign status.emit     = emit;
   assign status.out_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median      = median_ff;

   `SWM_ASSERT(a_fill_bound, fill_ff <= n_eff, "fill count exceeds window length")
   `SWM_ASSERT(a_ptr_bound, CNT_W'(ptr_ff) < n_eff, "oldest pointer outside the window")
   `SWM_ASSERT(a_rsp_source, $rose(rsp_valid_ff) |-> $past(cmd.do_update),
               "result appeared without an update")
   `SWM_ASSERT_NEVER(a_ptr_in_fill, !full && (ptr_ff != '0),
                     "oldest pointer moved before the window filled")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module tb_top;
   import swm_pkg::*;

   localparam int WINDOW_MAX   = 64;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1400;
   // Extra wait at the end of a drain, for the update of a sample that produced no median.
   localparam int DRAIN_CYCLES = 6;

   logic clock = 1'b0;
   logic reset;

   swm_req_if req_if ();
   swm_rsp_if rsp_if ();
   swm_csr_if csr_if ();

   sliding_window_median_top #(
      .WINDOW_MAX(WINDOW_MAX)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #6 clock = ~clock;

   // Shadow copy of the filter state, kept in step with every transfer seen on the ports.
   logic signed [SAMPLE_W-1:0] ring_samples [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] ordered_samples [WINDOW_MAX];
   logic [CFG_W-1:0]           window_cfg;
   int                         fill_cnt;
   int                         oldest_slot;
   logic [SAMPLE_W-1:0]        median_q [$];
   logic [SAMPLE_W-1:0]        expected_median;

   int error_count   = 0;
   int sent_count    = 0;
   int send_idle_pct = 32;
   int recv_idle_pct = 32;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // Window size as the block applies it: zero behaves as one, large values saturate.
   function automatic int active_window();
      if (window_cfg == '0) begin
         return 1;
      end
      if (window_cfg > WINDOW_MAX) begin
         return WINDOW_MAX;
      end
      return int'(window_cfg);
   endfunction

   // Insert after every entry that is less than or equal to the new value.
   function automatic void ordered_insert(input int count, input logic signed [SAMPLE_W-1:0] v);
      int pos;
      pos = 0;
      while (pos < count && ordered_samples[pos] <= v) begin
         pos++;
      end
      for (int i = count; i > pos; i--) begin
         ordered_samples[i] = ordered_samples[i-1];
      end
      ordered_samples[pos] = v;
   endfunction

   // Delete the first copy of a value that is known to sit in the window.
   function automatic void ordered_drop(input int count, input logic signed [SAMPLE_W-1:0] v);
      int pos;
      pos = 0;
      while (pos < count && ordered_samples[pos] < v) begin
         pos++;
      end
      if (pos >= count) begin
         return;
      end
      for (int i = pos; i + 1 < count; i++) begin
         ordered_samples[i] = ordered_samples[i+1];
      end
   endfunction

   // Advance the shadow state by one sample and queue the median it produces, if any.
   function automatic void median_update(input logic signed [SAMPLE_W-1:0] s);
      int n;
      int slot;
      logic signed [SAMPLE_W-1:0] evicted;
      n = active_window();
      if (fill_cnt < n) begin
         ring_samples[fill_cnt] = s;
         ordered_insert(fill_cnt, s);
         fill_cnt++;
         oldest_slot = 0;
         if (fill_cnt < n) begin
            return;
         end
      end else begin
         slot = oldest_slot % n;
         evicted = ring_samples[slot];
         ordered_drop(n, evicted);
         ordered_insert(n - 1, s);
         ring_samples[slot] = s;
         oldest_slot = (slot + 1) % n;
      end
      median_q.push_back(ordered_samples[(n - 1) / 2]);
   endfunction

   // Port monitor and scoreboard. All three channels are observed at the rising edge,
   // before any nonblocking update of that edge lands, so the values are the ones that
   // actually made the transfer.
   always @(posedge clock) begin
      if (reset) begin
         fill_cnt    = 0;
         oldest_slot = 0;
         window_cfg  = WINDOW_RESET;
      end else begin
         // A register write restarts the stream: the window must fill again.
         if (csr_if.valid && csr_if.ready) begin
            window_cfg  = csr_if.window_size;
            fill_cnt    = 0;
            oldest_slot = 0;
         end
         if (req_if.valid && req_if.ready) begin
            median_update(req_if.sample);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (median_q.size() == 0) begin
               $display("%0t: unexpected median transfer, expected none, actual %0d",
                        $time, $signed(rsp_if.median));
               error_count++;
            end else begin
               expected_median = median_q.pop_front();
               if (rsp_if.median !== expected_median) begin
                  $display("%0t: median mismatch, expected %0d, actual %0d",
                           $time, $signed(expected_median), $signed(rsp_if.median));
                  error_count++;
               end
            end
         end
      end
   end

   // Result receiver. It stalls at random, and on request holds ready low for a long
   // stretch so that the block backs up all the way to its sample input.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // Offers one sample, with random idle cycles in front, and returns at the edge of
   // its transfer. Valid stays high when the caller sends the next one right away.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= value;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   // Waits until every queued median has been received and the block has had time to
   // finish a sample that produced none.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (median_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the window size register; only ever done while the block is idle.
   task automatic write_window(input logic [CFG_W-1:0] size);
      wait_for_drain();
      csr_if.valid       <= 1'b1;
      csr_if.window_size <= size;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      csr_if.valid <= 1'b0;
   endtask

   // Mix of stream content: the two extremes, narrow ranges full of duplicates, and
   // fully random words.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         end
         1, 2, 3, 4: begin
            return $urandom_range(15) - 8;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Default window of three after reset, fed the extremes and repeated values.
   task automatic test_reset_window();
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h0000_0000);
      send_sample(32'hffff_ffff);
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h7fff_ffff);
      send_sample(32'h7fff_ffff);
      send_sample(32'd5);
      send_sample(32'd5);
      send_sample(32'd5);
   endtask

   // Size zero acts as a window of one, size one passes samples through, and a write
   // in the middle of a fill starts the window over.
   task automatic test_small_windows();
      write_window(7'd0);
      send_sample(32'h1234_5678);
      send_sample(32'h8000_0001);
      write_window(7'd1);
      send_sample(32'hfedc_ba98);
      send_sample(32'h7fff_fffe);
      write_window(7'd4);
      send_sample(32'd100);
      send_sample(32'd200);
      write_window(7'd2);
      send_sample(32'd7);
      send_sample(32'd7);
      send_sample(32'hffff_fff9);
   endtask

   // Random phases, each with its own window size, most of them small.
   task automatic test_random_stream();
      int goal;
      int sel;
      int items;
      logic [CFG_W-1:0] size;
      goal = sent_count + RANDOM_ITEMS;
      while (sent_count < goal) begin
         sel = $urandom_range(99);
         if (sel < 50) begin
            size = CFG_W'($urandom_range(8, 1));
         end else if (sel < 80) begin
            size = CFG_W'($urandom_range(32, 9));
         end else if (sel < 90) begin
            size = CFG_W'($urandom_range(64, 33));
         end else if (sel < 95) begin
            size = CFG_W'($urandom_range(127, 65));
         end else begin
            size = '0;
         end
         write_window(size);
         if (size > WINDOW_MAX) begin
            items = WINDOW_MAX + 20;
         end else if (size > 32) begin
            items = int'(size) + 20;
         end else begin
            items = int'(size) + int'($urandom_range(60, 10));
         end
         repeat (items) send_sample(pick_sample());
      end
   endtask

   // The receiver stops for a long stretch while samples keep coming, so the block has
   // to refuse transfers on its input until results drain again.
   task automatic test_back_pressure();
      write_window(7'd5);
      send_idle_pct = 0;
      hold_requests++;
      repeat (200) send_sample(pick_sample());
      send_idle_pct = 32;
   endtask

   // Both sides without idle cycles, so the block runs at its full rate.
   task automatic test_full_rate();
      write_window(7'd64);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (300) send_sample(pick_sample());
      write_window(7'd3);
      repeat (100) send_sample(pick_sample());
      send_idle_pct = 32;
      recv_idle_pct = 32;
   endtask

   initial begin
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.sample      <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.window_size <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_window();
      test_small_windows();
      test_random_stream();
      test_back_pressure();
      test_full_rate();

      wait_for_drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_if.sv
rtl/swm_ram.sv
rtl/swm_ctrl.sv
rtl/swm_datapath.sv
rtl/sliding_window_median_top.sv
dv/tb_top.sv
